// ===== rtl/core/sllt_pkg.sv =====
`timescale 1ns / 1ps

package sllt_pkg;

  localparam int ENTRIES_DEF      = 32;
  localparam int KEY_BITS_DEF     = 16;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LIST   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_WALK,
    S_INS_NEW,
    S_INS_PREV,
    S_DEL_LINK,
    S_DEL_FREE,
    S_RESP
  } sllt_state_t;

endpackage

// ===== rtl/core/sorted_linked_list_table_top.sv =====
`timescale 1ns / 1ps

// Sorted linked list table. Commands arrive as words on the in_ channel:
// insert a key with its payload handle, delete the first entry with a key,
// or list every entry in ascending key order. Results leave as words on the
// out_ channel; out_tlast marks the final word caused by a command.
// Insert and delete give one result word; list gives one word per entry, or
// one empty-status word when the list holds nothing.
// Entries live in two memories with registered reads (key and payload, link),
// and every insert that finds a free slot, every delete and every list
// walks the link chain from the head at one entry per cycle (a list walk
// only while the output register can take a word), since each link read
// supplies the next read address.
// A new command is taken only once the previous one is finished, but it may
// be taken while the last result still waits in the output register.
// Reset empties the list and frees all slots at once; no memory sweep runs,
// since fresh slots are handed out by a counter and freed ones are chained
// on a free list through the link memory.
// When the receiver stalls, the output register holds its word and a list
// walk pauses until the word is taken.
module sorted_linked_list_table_top #(
  parameter int ENTRIES      = sllt_pkg::ENTRIES_DEF,
  parameter int KEY_BITS     = sllt_pkg::KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = sllt_pkg::PAYLOAD_BITS_DEF,
  localparam int TDATA_W     = ((KEY_BITS + PAYLOAD_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [TDATA_W-1:0]            in_tdata,   // key, payload
  input  logic [sllt_pkg::CMD_W-1:0]    in_tuser,   // command
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [TDATA_W-1:0]            out_tdata,  // entry_key, entry_payload
  output logic [sllt_pkg::STATUS_W-1:0] out_tuser,  // status
  output logic                          out_tlast   // last
);
  import sllt_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int IW = $clog2(ENTRIES + 1);
  localparam int DW = KEY_BITS + PAYLOAD_BITS;
  localparam logic [IW-1:0] END_IDX = IW'(ENTRIES);

  // Memories: key and payload per slot, and the link of each slot.
  logic [DW-1:0] data_mem [ENTRIES];
  logic [IW-1:0] link_mem [ENTRIES];
  logic [DW-1:0] data_rd_r;
  logic [IW-1:0] link_rd_r;

  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic          data_we;
  logic [AW-1:0] data_wa;
  logic [DW-1:0] data_wd;
  logic          link_we;
  logic [AW-1:0] link_wa;
  logic [IW-1:0] link_wd;

  sllt_state_t state_r, state_nxt;
  logic [CMD_W-1:0]        cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0]     key_r, key_nxt;
  logic [PAYLOAD_BITS-1:0] pay_r, pay_nxt;
  logic [IW-1:0]           head_r, head_nxt;
  logic [IW-1:0]           free_head_r, free_head_nxt;
  logic [IW-1:0]           fresh_r, fresh_nxt;
  logic [IW-1:0]           cur_r, cur_nxt;
  logic [IW-1:0]           prev_r, prev_nxt;
  logic [IW-1:0]           slot_r, slot_nxt;
  logic [IW-1:0]           succ_r, succ_nxt;
  logic [STATUS_W-1:0]     res_status_r, res_status_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]     out_status_r, out_status_nxt;
  logic [KEY_BITS-1:0]     out_key_r, out_key_nxt;
  logic [PAYLOAD_BITS-1:0] out_pay_r, out_pay_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [CMD_W-1:0]        cmd_cur;
  logic [KEY_BITS-1:0]     key_rd;
  logic [PAYLOAD_BITS-1:0] pay_rd;
  logic                    link_end;
  logic                    head_end;
  logic                    free_empty;
  logic                    fresh_full;
  logic                    out_free;
  logic                    in_fire;
  logic                    do_start;
  sllt_state_t             start_st;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cmd_cur    = (state_r == S_IDLE) ? in_tuser : cmd_r;
  assign key_rd     = data_rd_r[KEY_BITS-1:0];
  assign pay_rd     = data_rd_r[DW-1:KEY_BITS];
  assign link_end   = (link_rd_r == END_IDX);
  assign head_end   = (head_r == END_IDX);
  assign free_empty = (free_head_r == END_IDX);
  assign fresh_full = (fresh_r == END_IDX);
  assign out_free   = !out_valid_r || out_tready;

  // Where a walk from the head goes first: an empty list ends it at once.
  assign start_st = !head_end ? S_WALK :
                    (cmd_cur == CMD_INSERT) ? S_INS_NEW : S_RESP;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_tuser)
            CMD_INSERT: begin
              if (!free_empty) begin
                state_nxt = S_POP;
              end else if (!fresh_full) begin
                state_nxt = start_st;
              end else begin
                state_nxt = S_RESP;
              end
            end
            CMD_DELETE: state_nxt = start_st;
            CMD_LIST:   state_nxt = start_st;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_POP: state_nxt = start_st;
      S_WALK: begin
        case (cmd_r)
          CMD_INSERT: begin
            if ((key_rd > key_r) || link_end) begin
              state_nxt = S_INS_NEW;
            end
          end
          CMD_DELETE: begin
            if (key_rd == key_r) begin
              state_nxt = S_DEL_LINK;
            end else if (link_end) begin
              state_nxt = S_RESP;
            end
          end
          CMD_LIST: begin
            if (out_free && link_end) begin
              state_nxt = S_IDLE;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_INS_NEW:  state_nxt = S_INS_PREV;
      S_INS_PREV: state_nxt = S_RESP;
      S_DEL_LINK: state_nxt = S_DEL_FREE;
      S_DEL_FREE: state_nxt = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    pay_nxt        = pay_r;
    head_nxt       = head_r;
    free_head_nxt  = free_head_r;
    fresh_nxt      = fresh_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    slot_nxt       = slot_r;
    succ_nxt       = succ_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_pay_nxt    = out_pay_r;
    out_last_nxt   = out_last_r;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = head_r[AW-1:0];
    data_we        = 1'b0;
    data_wa        = slot_r[AW-1:0];
    data_wd        = {pay_r, key_r};
    link_we        = 1'b0;
    link_wa        = slot_r[AW-1:0];
    link_wd        = cur_r;
    do_start       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt = in_tuser;
          key_nxt = in_tdata[KEY_BITS-1:0];
          pay_nxt = in_tdata[DW-1:KEY_BITS];
          case (in_tuser)
            CMD_INSERT: begin
              if (!free_empty) begin
                // Pop a freed slot; its link holds the rest of the free list.
                slot_nxt    = free_head_r;
                mem_rd_en   = 1'b1;
                mem_rd_addr = free_head_r[AW-1:0];
              end else if (!fresh_full) begin
                slot_nxt  = fresh_r;
                fresh_nxt = fresh_r + 1'b1;
                do_start  = 1'b1;
              end else begin
                res_status_nxt = ST_FULL;
              end
            end
            CMD_DELETE: do_start = 1'b1;
            CMD_LIST:   do_start = 1'b1;
            default:    do_start = 1'b0;
          endcase
        end
      end
      S_POP: begin
        free_head_nxt = link_rd_r;
        do_start      = 1'b1;
      end
      S_WALK: begin
        case (cmd_r)
          CMD_INSERT: begin
            if (key_rd <= key_r) begin
              prev_nxt = cur_r;
              cur_nxt  = link_rd_r;
              if (!link_end) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = link_rd_r[AW-1:0];
              end
            end
          end
          CMD_DELETE: begin
            if (key_rd == key_r) begin
              succ_nxt = link_rd_r;
            end else begin
              prev_nxt = cur_r;
              cur_nxt  = link_rd_r;
              if (link_end) begin
                res_status_nxt = ST_NOT_FOUND;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = link_rd_r[AW-1:0];
              end
            end
          end
          CMD_LIST: begin
            if (out_free) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OK;
              out_key_nxt    = key_rd;
              out_pay_nxt    = pay_rd;
              out_last_nxt   = link_end;
              cur_nxt        = link_rd_r;
              if (!link_end) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = link_rd_r[AW-1:0];
              end
            end
          end
          default: mem_rd_en = 1'b0;
        endcase
      end
      S_INS_NEW: begin
        data_we = 1'b1;
        link_we = 1'b1;
      end
      S_INS_PREV: begin
        res_status_nxt = ST_OK;
        if (prev_r == END_IDX) begin
          head_nxt = slot_r;
        end else begin
          link_we = 1'b1;
          link_wa = prev_r[AW-1:0];
          link_wd = slot_r;
        end
      end
      S_DEL_LINK: begin
        if (prev_r == END_IDX) begin
          head_nxt = succ_r;
        end else begin
          link_we = 1'b1;
          link_wa = prev_r[AW-1:0];
          link_wd = succ_r;
        end
      end
      S_DEL_FREE: begin
        // The removed slot goes on top of the free list.
        res_status_nxt = ST_OK;
        link_we        = 1'b1;
        link_wa        = cur_r[AW-1:0];
        link_wd        = free_head_r;
        free_head_nxt  = cur_r;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_key_nxt    = key_r;
          out_pay_nxt    = '0;
          out_last_nxt   = 1'b1;
        end
      end
      default: mem_rd_en = 1'b0;
    endcase

    if (do_start) begin
      cur_nxt  = head_r;
      prev_nxt = END_IDX;
      if (head_end) begin
        res_status_nxt = (cmd_cur == CMD_LIST) ? ST_EMPTY : ST_NOT_FOUND;
      end else begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = head_r[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[data_wa] <= data_wd;
    end
    if (mem_rd_en) begin
      data_rd_r <= data_mem[mem_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (mem_rd_en) begin
      link_rd_r <= link_mem[mem_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= END_IDX;
      free_head_r <= END_IDX;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      free_head_r <= free_head_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    pay_r        <= pay_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    slot_r       <= slot_nxt;
    succ_r       <= succ_nxt;
    res_status_r <= res_status_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_pay_r    <= out_pay_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'({out_pay_r, out_key_r});
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import sllt_pkg::*;

  localparam int ENTRIES      = ENTRIES_DEF;
  localparam int KEY_BITS     = KEY_BITS_DEF;
  localparam int PAYLOAD_BITS = PAYLOAD_BITS_DEF;
  localparam int TDATA_W      = ((KEY_BITS + PAYLOAD_BITS + 7) / 8) * 8;
  localparam int END_MARK     = ENTRIES;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = ENTRIES + 20;
  localparam int MAX_REPORTS  = 10;

  // The block ignores the one command code that has no meaning.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [KEY_BITS-1:0]     entry_key;
    logic [PAYLOAD_BITS-1:0] entry_payload;
    logic                    last;
  } result_word_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [TDATA_W-1:0]  in_tdata   = '0;
  logic [CMD_W-1:0]    in_tuser   = CMD_INSERT;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [TDATA_W-1:0]  out_tdata;
  logic [STATUS_W-1:0] out_tuser;
  logic                out_tlast;

  sorted_linked_list_table_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // key, payload
    .in_tuser   (in_tuser),   // command
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // entry_key, entry_payload
    .out_tuser  (out_tuser),  // status
    .out_tlast  (out_tlast)   // last
  );

  // Shadow copy of the linked table.
  logic [KEY_BITS-1:0]     tbl_key  [ENTRIES];
  logic [PAYLOAD_BITS-1:0] tbl_pay  [ENTRIES];
  int                      tbl_next [ENTRIES];
  bit                      tbl_used [ENTRIES];
  int                      tbl_head  = END_MARK;
  int                      tbl_count = 0;

  result_word_t pending_words[$];

  bit steady_mode = 1'b0;
  int cycle_count = 0;
  int fail_count  = 0;
  int words_checked = 0;
  int cmd_count [4];
  int full_refusals = 0;
  int delete_misses = 0;
  int empty_lists   = 0;
  int longest_list  = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still awaited",
               cycle_count, pending_words.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= steady_mode || ($urandom_range(99) >= 38);
  end

  // Applies one accepted command to the shadow table and queues the words it
  // should produce.
  function automatic void predict_list_op(input logic [CMD_W-1:0] cmd,
                                          input logic [KEY_BITS-1:0] key,
                                          input logic [PAYLOAD_BITS-1:0] pay);
    int slot;
    int prev;
    int cur;
    int walked;
    cmd_count[cmd]++;
    case (cmd)
      CMD_INSERT: begin
        slot = END_MARK;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
          if (!tbl_used[i]) slot = i;
        end
        if (slot == END_MARK) begin
          full_refusals++;
          pending_words.push_back('{ST_FULL, key, '0, 1'b1});
        end else begin
          // Equal keys go after the ones already stored.
          prev = END_MARK;
          cur  = tbl_head;
          while (cur != END_MARK && tbl_key[cur] <= key) begin
            prev = cur;
            cur  = tbl_next[cur];
          end
          tbl_key[slot]  = key;
          tbl_pay[slot]  = pay;
          tbl_used[slot] = 1'b1;
          tbl_next[slot] = cur;
          if (prev == END_MARK) tbl_head = slot;
          else tbl_next[prev] = slot;
          tbl_count++;
          pending_words.push_back('{ST_OK, key, '0, 1'b1});
        end
      end
      CMD_DELETE: begin
        prev = END_MARK;
        cur  = tbl_head;
        while (cur != END_MARK && tbl_key[cur] != key) begin
          prev = cur;
          cur  = tbl_next[cur];
        end
        if (cur == END_MARK) begin
          delete_misses++;
          pending_words.push_back('{ST_NOT_FOUND, key, '0, 1'b1});
        end else begin
          if (prev == END_MARK) tbl_head = tbl_next[cur];
          else tbl_next[prev] = tbl_next[cur];
          tbl_used[cur] = 1'b0;
          tbl_count--;
          pending_words.push_back('{ST_OK, key, '0, 1'b1});
        end
      end
      CMD_LIST: begin
        if (tbl_head == END_MARK) begin
          empty_lists++;
          pending_words.push_back('{ST_EMPTY, key, '0, 1'b1});
        end else begin
          cur    = tbl_head;
          walked = 0;
          while (cur != END_MARK) begin
            pending_words.push_back('{ST_OK, tbl_key[cur], tbl_pay[cur],
                                      tbl_next[cur] == END_MARK});
            cur = tbl_next[cur];
            walked++;
          end
          if (walked > longest_list) longest_list = walked;
        end
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk) begin
    result_word_t got;
    result_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[KEY_BITS-1:0],
              out_tdata[KEY_BITS +: PAYLOAD_BITS], out_tlast};
      if (pending_words.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected word status=%0d key=%h payload=%h last=%b",
                   $realtime, got.status, got.entry_key, got.entry_payload, got.last);
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (got !== want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display({"%0t: mismatch expected status=%0d key=%h payload=%h last=%b,",
                      " got status=%0d key=%h payload=%h last=%b"},
                     $realtime, want.status, want.entry_key, want.entry_payload,
                     want.last, got.status, got.entry_key, got.entry_payload,
                     got.last);
        end
      end
    end
  end

  task automatic send_word(input logic [CMD_W-1:0] cmd,
                           input logic [KEY_BITS-1:0] key,
                           input logic [PAYLOAD_BITS-1:0] pay);
    int gap;
    if (!steady_mode && $urandom_range(99) < 38) begin
      gap = $urandom_range(45, 1);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= TDATA_W'({pay, key});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_list_op(cmd, key, pay);
  endtask

  // Small keys dominate so that equal keys and delete hits are common.
  function automatic logic [KEY_BITS-1:0] random_key();
    int r;
    r = $urandom_range(99);
    if (r < 45) return KEY_BITS'($urandom_range(15));
    if (r < 50) return '0;
    if (r < 55) return '1;
    return KEY_BITS'($urandom());
  endfunction

  function automatic logic [KEY_BITS-1:0] pick_stored_key();
    int pick;
    int cur;
    if (tbl_count == 0) return random_key();
    pick = $urandom_range(tbl_count - 1);
    cur  = tbl_head;
    repeat (pick) cur = tbl_next[cur];
    return tbl_key[cur];
  endfunction

  task automatic test_empty_table();
    send_word(CMD_LIST, 16'hA5A5, 32'h0);
    send_word(CMD_DELETE, 16'h0007, 32'hFFFF_FFFF);
  endtask

  task automatic test_order_and_extremes();
    send_word(CMD_INSERT, 16'h0000, 32'h0000_0000);
    send_word(CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(CMD_INSERT, 16'd100, 32'h1234_5678);
    send_word(CMD_INSERT, 16'd100, 32'h8765_4321);
    send_word(CMD_INSERT, 16'd50, 32'hAAAA_5555);
    send_word(CMD_INSERT, 16'd100, 32'h5555_AAAA);
    send_word(CMD_LIST, 16'h5A5A, 32'h0);
    // Removes only the oldest of the three equal keys.
    send_word(CMD_DELETE, 16'd100, 32'h0);
    send_word(CMD_DELETE, 16'h0000, 32'h0);
    send_word(CMD_DELETE, 16'hFFFF, 32'h0);
    send_word(CMD_DELETE, 16'd999, 32'h0);
    send_word(CMD_LIST, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(CMD_LIST, 16'h0000, 32'h0);
  endtask

  task automatic test_full_table();
    while (tbl_count < ENTRIES) send_word(CMD_INSERT, random_key(), $urandom());
    repeat (2) send_word(CMD_INSERT, random_key(), $urandom());
    send_word(CMD_LIST, random_key(), $urandom());
    repeat (ENTRIES / 2) send_word(CMD_DELETE, pick_stored_key(), $urandom());
    send_word(CMD_LIST, random_key(), $urandom());
    while (tbl_count > 0) send_word(CMD_DELETE, pick_stored_key(), $urandom());
    send_word(CMD_LIST, random_key(), $urandom());
  endtask

  // Four phases: growth, shrinkage, growth again, then a balanced mix.
  task automatic test_random_mix(input int items);
    int done;
    int phase;
    int r;
    int insert_pct;
    int delete_pct;
    done = 0;
    while (done < items) begin
      steady_mode = (done >= items / 3) && (done < items / 2);
      phase = (done * 4) / items;
      case (phase)
        0, 2: begin
          insert_pct = 70;
          delete_pct = 15;
        end
        1: begin
          insert_pct = 20;
          delete_pct = 65;
        end
        default: begin
          insert_pct = 40;
          delete_pct = 40;
        end
      endcase
      r = $urandom_range(99);
      if (r < insert_pct) begin
        send_word(CMD_INSERT, random_key(), $urandom());
        done++;
      end else if (r < insert_pct + delete_pct) begin
        if ($urandom_range(99) < 75) send_word(CMD_DELETE, pick_stored_key(), $urandom());
        else send_word(CMD_DELETE, random_key(), $urandom());
        done++;
      end else if (r < 97) begin
        send_word(CMD_LIST, random_key(), $urandom());
        done++;
      end else begin
        send_word(CMD_UNUSED, random_key(), $urandom());
      end
    end
    steady_mode = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_next[i] = END_MARK;
      tbl_used[i] = 1'b0;
    end
    foreach (cmd_count[i]) cmd_count[i] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_order_and_extremes();
    test_full_table();
    test_random_mix(300);

    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d inserts (%0d refused as full), %0d deletes (%0d misses),",
             cmd_count[CMD_INSERT], full_refusals, cmd_count[CMD_DELETE],
             delete_misses);
    $display("%0d lists (%0d empty, longest %0d entries), %0d ignored commands.",
             cmd_count[CMD_LIST], empty_lists, longest_list, cmd_count[CMD_UNUSED]);
    $display("Checked %0d result words, %0d failures.", words_checked, fail_count);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
